@@ rtl/core/txc_pkg.sv @@
// Shared types, request codes and constants of the text console character writer.
package txc_pkg;

    localparam int COLUMNS_DEFAULT = 80;

    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_BACK = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [7:0] BG_ATTR_RESET = 8'd16;
    localparam logic [7:0] FG_ATTR_RESET = 8'd15;

    localparam logic CFG_BG_ATTR = 1'b0;
    localparam logic CFG_FG_ATTR = 1'b1;

    localparam int POS_W = 15;

    localparam logic [1:0] TAB_LAST_STEP = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef logic [2:0] kind_t;

    localparam kind_t OP_CHAR    = 3'd0;
    localparam kind_t OP_TAB     = 3'd1;
    localparam kind_t OP_NEWLINE = 3'd2;
    localparam kind_t OP_SET     = 3'd3;
    localparam kind_t OP_BACK    = 3'd4;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
    } entry_t;

endpackage

@@ rtl/core/txc_cfg.sv @@
// APB-style register file holding the background and foreground attributes.
module txc_cfg
    import txc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  attr
);

    logic [7:0] bg_attr_reg;
    logic [7:0] fg_attr_reg;
    logic       wr_en;
    logic       reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_attr_reg <= BG_ATTR_RESET;
            fg_attr_reg <= FG_ATTR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                CFG_BG_ATTR: bg_attr_reg <= pwdata[7:0];
                CFG_FG_ATTR: fg_attr_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            CFG_BG_ATTR: prdata = {24'd0, bg_attr_reg};
            CFG_FG_ATTR: prdata = {24'd0, fg_attr_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign attr = bg_attr_reg | fg_attr_reg;

endmodule

@@ rtl/core/txc_front.sv @@
// Front end: accepts request items and classifies them into queue entries.
module txc_front
    import txc_pkg::*;
(
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] char_code,
    input  logic [7:0] col,
    input  logic [7:0] row,
    input  logic [7:0] amount,
    input  logic       q_full,
    output logic       push,
    output entry_t     push_entry
);

    logic has_work;

    assign req_stall = q_full;

    always_comb
    begin
        has_work         = 1'b1;
        push_entry.kind  = OP_CHAR;
        push_entry.arg_a = char_code;
        push_entry.arg_b = 8'd0;
        case (req_type)
            REQ_CHAR:
            begin
                if (char_code == CHAR_NEWLINE)
                begin
                    push_entry.kind = OP_NEWLINE;
                end
                else if (char_code == CHAR_TAB)
                begin
                    push_entry.kind = OP_TAB;
                end
            end
            REQ_SET:
            begin
                push_entry.kind  = OP_SET;
                push_entry.arg_a = col;
                push_entry.arg_b = row;
            end
            REQ_BACK:
            begin
                push_entry.kind  = OP_BACK;
                push_entry.arg_a = amount;
            end
            default: has_work = 1'b0;
        endcase
    end

    assign push = req_valid && !req_stall && has_work;

endmodule

@@ rtl/core/txc_queue.sv @@
// Two-entry queue between the front end and the back end.
module txc_queue
    import txc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   q_valid,
    output logic   q_full,
    output entry_t q_entry
);

    entry_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> !pop)
        else $error("queue read while empty");

endmodule

@@ rtl/core/txc_back.sv @@
// Back end: executes queued entries, moves the cursor and registers each result item.
module txc_back
    import txc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  entry_t           q_entry,
    output logic             pop,
    input  logic [7:0]       attr,
    output logic             res_valid,
    input  logic             res_stall,
    output logic             cell_write,
    output logic [POS_W-1:0] cell_addr,
    output logic [15:0]      cell_data,
    output logic [POS_W-1:0] cursor_pos,
    output logic             last
);

    localparam logic [7:0] COLS_B = COLUMNS[7:0];

    logic [7:0]       col_reg;
    logic [7:0]       row_reg;
    logic [POS_W-1:0] pos_reg;
    logic [1:0]       step_reg;
    logic             res_valid_reg;
    logic             cell_write_reg;
    logic [POS_W-1:0] cell_addr_reg;
    logic [15:0]      cell_data_reg;
    logic [POS_W-1:0] cursor_pos_reg;
    logic             last_reg;

    logic             fire;
    logic             wrap;
    logic [7:0]       adv_col;
    logic [7:0]       adv_row;
    logic [7:0]       col_next;
    logic [7:0]       row_next;
    logic [15:0]      row_prod;
    logic [16:0]      pos_sum;
    logic [POS_W-1:0] pos_next;
    logic             wr_c;
    logic [POS_W-1:0] addr_c;
    logic [15:0]      data_c;
    logic             last_c;

    assign fire = q_valid && (!res_valid_reg || !res_stall);

    assign wrap    = ({1'b0, col_reg} + 9'd1) >= 9'(COLUMNS);
    assign adv_col = wrap ? 8'd0 : col_reg + 8'd1;
    assign adv_row = wrap ? row_reg + 8'd1 : row_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        wr_c     = 1'b0;
        addr_c   = '0;
        data_c   = 16'd0;
        last_c   = 1'b1;
        case (q_entry.kind)
            OP_CHAR:
            begin
                col_next = adv_col;
                row_next = adv_row;
                wr_c     = 1'b1;
                addr_c   = pos_reg;
                data_c   = {attr, q_entry.arg_a};
            end
            OP_TAB:
            begin
                col_next = adv_col;
                row_next = adv_row;
                wr_c     = 1'b1;
                addr_c   = pos_reg;
                data_c   = {attr, CHAR_SPACE};
                last_c   = (adv_col[1:0] == 2'd0) || (step_reg == TAB_LAST_STEP);
            end
            OP_NEWLINE:
            begin
                col_next = 8'd0;
                row_next = row_reg + 8'd1;
            end
            OP_SET:
            begin
                col_next = q_entry.arg_a;
                row_next = q_entry.arg_b;
            end
            OP_BACK:
            begin
                col_next = col_reg - q_entry.arg_a;
            end
            default: ;
        endcase
    end

    assign row_prod = row_next * COLS_B;
    assign pos_sum  = {1'b0, row_prod} + {9'd0, col_next};
    assign pos_next = pos_sum[POS_W-1:0];

    assign pop = fire && last_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            pos_reg       <= '0;
            step_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                pos_reg       <= pos_next;
                step_reg      <= last_c ? 2'd0 : step_reg + 2'd1;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cell_write_reg <= wr_c;
            cell_addr_reg  <= addr_c;
            cell_data_reg  <= data_c;
            cursor_pos_reg <= pos_next;
            last_reg       <= last_c;
        end
    end

    assign res_valid  = res_valid_reg;
    assign cell_write = cell_write_reg;
    assign cell_addr  = cell_addr_reg;
    assign cell_data  = cell_data_reg;
    assign cursor_pos = cursor_pos_reg;
    assign last       = last_reg;

    a_tab_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 2'd0 |-> q_valid && q_entry.kind == OP_TAB && col_reg[1:0] != 2'd0)
        else $error("tab expansion without a tab at the queue head");

    a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == POS_W'({1'b0, 16'(row_reg * COLS_B)} + {9'd0, col_reg}))
        else $error("cursor position out of step with row and column");

    a_result_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg && cursor_pos_reg == pos_reg)
        else $error("executed entry did not leave a matching result");

endmodule

@@ rtl/core/text_console_char_writer.sv @@
// Top level of the text console character writer.
//
// Request items arrive on req_valid/req_stall with req_type, char_code, col,
// row and amount; an item is taken at a clock edge with req_valid high and
// req_stall low. Result items leave on res_valid/res_stall with cell_write,
// cell_addr, cell_data, cursor_pos and last, taken the same way.
// The background and foreground attributes are written over the APB-style
// port at byte addresses 0 and 4 and are ORed into each written cell.
// A character, newline, set or move-back request gives one result item; a tab
// gives one to four, one per cycle unless stalled, with last high on the final one.
// With an empty queue, a request taken at an edge is written to the queue,
// executed from its head and its result registered. Unless res_stall holds
// it, the back end turns out one result item per cycle, set by its single
// cursor update and position multiply, so plain requests sustain one per cycle.
// Requests of type 3 are taken and give no result.
// A two-entry queue parts the front end from the back end; while the
// receiver stalls, the result register holds and the queue fills, and
// req_stall rises once both entries are occupied.
// Reset puts the cursor at row 0, column 0 and the attributes at 16 and 15.
module text_console_char_writer
    import txc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       req_type,
    input  logic [7:0]       char_code,
    input  logic [7:0]       col,
    input  logic [7:0]       row,
    input  logic [7:0]       amount,
    output logic             res_valid,
    input  logic             res_stall,
    output logic             cell_write,
    output logic [POS_W-1:0] cell_addr,
    output logic [15:0]      cell_data,
    output logic [POS_W-1:0] cursor_pos,
    output logic             last
);

    logic [7:0] attr;
    logic       push;
    entry_t     push_entry;
    logic       pop;
    logic       q_valid;
    logic       q_full;
    entry_t     q_entry;

    txc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    txc_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .amount     (amount),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    txc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .q_entry    (q_entry)
    );

    txc_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .attr       (attr),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .cell_write (cell_write),
        .cell_addr  (cell_addr),
        .cell_data  (cell_data),
        .cursor_pos (cursor_pos),
        .last       (last)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the text console character writer.
module testbench;
    import txc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [2:0] ADDR_BG_ATTR = {CFG_BG_ATTR, 2'b00};
    localparam logic [2:0] ADDR_FG_ATTR = {CFG_FG_ATTR, 2'b00};
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct {
        logic             cell_write;
        logic [POS_W-1:0] cell_addr;
        logic [15:0]      cell_data;
        logic [POS_W-1:0] cursor_pos;
        logic             last;
    } console_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             req_valid = 1'b0;
    logic             req_stall;
    logic [1:0]       req_type = REQ_CHAR;
    logic [7:0]       char_code = '0;
    logic [7:0]       col = '0;
    logic [7:0]       row = '0;
    logic [7:0]       amount = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic             cell_write;
    logic [POS_W-1:0] cell_addr;
    logic [15:0]      cell_data;
    logic [POS_W-1:0] cursor_pos;
    logic             last;

    console_result_t  pending_results[$];
    logic [7:0]       cursor_col_m;
    logic [7:0]       cursor_row_m;
    logic [7:0]       bg_attr_m;
    logic [7:0]       fg_attr_m;
    int               error_count = 0;
    int               cycle_count = 0;
    int               gap_pct = 0;
    int               stall_pct = 0;
    int               hold_req_cnt = 0;
    int               hold_ack_cnt = 0;
    int               hold_left = 0;

    text_console_char_writer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .amount     (amount),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .cell_write (cell_write),
        .cell_addr  (cell_addr),
        .cell_data  (cell_data),
        .cursor_pos (cursor_pos),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [POS_W-1:0] cell_index(input logic [7:0] r, input logic [7:0] c);
        int unsigned p;
        p = int'(r) * COLUMNS_DEFAULT + int'(c);
        return p[POS_W-1:0];
    endfunction

    task automatic write_console_cell(input logic [7:0] ch, output console_result_t res);
        res.cell_write = 1'b1;
        res.cell_addr  = cell_index(cursor_row_m, cursor_col_m);
        res.cell_data  = {bg_attr_m | fg_attr_m, ch};
        if (int'(cursor_col_m) + 1 >= COLUMNS_DEFAULT)
        begin
            cursor_col_m = 8'd0;
            cursor_row_m = cursor_row_m + 8'd1;
        end
        else
            cursor_col_m = cursor_col_m + 8'd1;
        res.cursor_pos = cell_index(cursor_row_m, cursor_col_m);
        res.last       = 1'b0;
    endtask

    task automatic predict_console(input logic [1:0] rt, input logic [7:0] ch,
                                   input logic [7:0] c, input logic [7:0] r,
                                   input logic [7:0] a);
        console_result_t batch[4];
        int n;
        n = 0;
        if (rt == REQ_CHAR && ch == CHAR_TAB)
        begin
            if (cursor_col_m[1:0] == 2'd0)
            begin
                write_console_cell(CHAR_SPACE, batch[n]);
                n++;
            end
            while (cursor_col_m[1:0] != 2'd0 && n < 4)
            begin
                write_console_cell(CHAR_SPACE, batch[n]);
                n++;
            end
        end
        else if (rt == REQ_CHAR && ch != CHAR_NEWLINE)
        begin
            write_console_cell(ch, batch[0]);
            n = 1;
        end
        else if (rt != REQ_UNUSED)
        begin
            if (rt == REQ_CHAR)
            begin
                cursor_col_m = 8'd0;
                cursor_row_m = cursor_row_m + 8'd1;
            end
            else if (rt == REQ_SET)
            begin
                cursor_col_m = c;
                cursor_row_m = r;
            end
            else
                cursor_col_m = cursor_col_m - a;
            batch[0].cell_write = 1'b0;
            batch[0].cell_addr  = '0;
            batch[0].cell_data  = '0;
            batch[0].cursor_pos = cell_index(cursor_row_m, cursor_col_m);
            n = 1;
        end
        for (int i = 0; i < n; i++)
        begin
            batch[i].last = (i == n - 1);
            pending_results.push_back(batch[i]);
        end
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_request(input logic [1:0] rt, input logic [7:0] ch,
                                input logic [7:0] c, input logic [7:0] r,
                                input logic [7:0] a);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rt;
        char_code <= ch;
        col       <= c;
        row       <= r;
        amount    <= a;
        do
            @(posedge clk);
        while (!(req_valid === 1'b1 && req_stall === 1'b0));
        predict_console(rt, ch, c, r, a);
    endtask

    task automatic send_random_request();
        logic [1:0] rt;
        logic [7:0] ch;
        logic [7:0] c;
        logic [7:0] r;
        logic [7:0] a;
        int sel;
        sel = $urandom_range(99);
        rt  = REQ_CHAR;
        ch  = 8'($urandom);
        c   = 8'($urandom);
        r   = 8'($urandom);
        a   = 8'($urandom);
        if (sel < 50)
            ch = 8'($urandom);
        else if (sel < 60)
            ch = CHAR_NEWLINE;
        else if (sel < 75)
            ch = CHAR_TAB;
        else if (sel < 85)
        begin
            rt = REQ_SET;
            if ($urandom_range(3) != 0)
                c = 8'($urandom_range(COLUMNS_DEFAULT - 1));
        end
        else if (sel < 95)
        begin
            rt = REQ_BACK;
            if ($urandom_range(3) != 0)
                a = 8'($urandom_range(8));
        end
        else
            rt = REQ_UNUSED;
        send_request(rt, ch, c, r, a);
    endtask

    task automatic stop_requests();
        req_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check_read(input logic [2:0] addr, input logic [7:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== {24'd0, want})
            report_error($sformatf("read of address %0d gave 0x%h, expected 0x%h",
                                   addr, got, want));
    endtask

    task automatic set_attributes(input logic [7:0] bg, input logic [7:0] fg);
        apb_write(ADDR_BG_ATTR, bg);
        bg_attr_m = bg;
        apb_write(ADDR_FG_ATTR, fg);
        fg_attr_m = fg;
        apb_check_read(ADDR_BG_ATTR, bg_attr_m);
        apb_check_read(ADDR_FG_ATTR, fg_attr_m);
    endtask

    always @(posedge clk)
    begin
        if (hold_req_cnt != hold_ack_cnt)
        begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            res_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result: addr %0d data 0x%h pos %0d",
                                       cell_addr, cell_data, cursor_pos));
            else
            begin
                want = pending_results.pop_front();
                if (cell_write !== want.cell_write)
                    report_error($sformatf("cell_write %b, expected %b",
                                           cell_write, want.cell_write));
                if (cell_addr !== want.cell_addr)
                    report_error($sformatf("cell_addr %0d, expected %0d",
                                           cell_addr, want.cell_addr));
                if (cell_data !== want.cell_data)
                    report_error($sformatf("cell_data 0x%h, expected 0x%h",
                                           cell_data, want.cell_data));
                if (cursor_pos !== want.cursor_pos)
                    report_error($sformatf("cursor_pos %0d, expected %0d",
                                           cursor_pos, want.cursor_pos));
                if (last !== want.last)
                    report_error($sformatf("last %b, expected %b", last, want.last));
            end
        end
    end

    task automatic test_reset_values();
        apb_check_read(ADDR_BG_ATTR, BG_ATTR_RESET);
        apb_check_read(ADDR_FG_ATTR, FG_ATTR_RESET);
    endtask

    task automatic test_directed_requests();
        gap_pct   = 20;
        stall_pct = 30;
        send_request(REQ_CHAR, 8'h41, 8'h00, 8'h00, 8'h00);
        send_request(REQ_CHAR, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_CHAR, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(REQ_CHAR, CHAR_TAB, 8'h00, 8'h00, 8'h00);
        send_request(REQ_CHAR, CHAR_TAB, 8'h00, 8'h00, 8'h00);
        send_request(REQ_SET, 8'h00, 8'd1, 8'd0, 8'h00);
        send_request(REQ_CHAR, CHAR_TAB, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_SET, CHAR_TAB, 8'd2, 8'd1, 8'hFF);
        send_request(REQ_CHAR, CHAR_TAB, 8'h00, 8'h00, 8'h00);
        send_request(REQ_CHAR, CHAR_NEWLINE, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_SET, CHAR_NEWLINE, 8'd79, 8'd2, 8'h00);
        send_request(REQ_CHAR, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_request(REQ_SET, 8'h00, 8'd200, 8'd3, 8'h00);
        send_request(REQ_CHAR, 8'hA5, 8'h00, 8'h00, 8'h00);
        send_request(REQ_SET, 8'h00, 8'd252, 8'd4, 8'h00);
        send_request(REQ_CHAR, CHAR_TAB, 8'h00, 8'h00, 8'h00);
        send_request(REQ_BACK, 8'hFF, 8'hFF, 8'hFF, 8'd5);
        send_request(REQ_BACK, 8'h00, 8'h00, 8'h00, 8'd0);
        send_request(REQ_BACK, 8'h00, 8'h00, 8'h00, 8'd255);
        send_request(REQ_SET, 8'h00, 8'd255, 8'd255, 8'h00);
        send_request(REQ_CHAR, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(REQ_SET, 8'h00, 8'd10, 8'd255, 8'h00);
        send_request(REQ_CHAR, CHAR_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_request(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(REQ_CHAR, 8'h7E, 8'h00, 8'h00, 8'h00);
        stop_requests();
        wait_quiet();
    endtask

    task automatic test_attribute_settings();
        logic [7:0] settings[4][2];
        settings = '{'{8'h00, 8'h00}, '{8'hFF, 8'hFF}, '{8'hA5, 8'h5A},
                     '{BG_ATTR_RESET, FG_ATTR_RESET}};
        gap_pct   = 0;
        stall_pct = 0;
        for (int s = 0; s < 4; s++)
        begin
            set_attributes(settings[s][0], settings[s][1]);
            send_request(REQ_SET, 8'h00, 8'd1, 8'd5, 8'h00);
            send_request(REQ_CHAR, 8'h61, 8'h00, 8'h00, 8'h00);
            send_request(REQ_CHAR, CHAR_TAB, 8'h00, 8'h00, 8'h00);
            send_request(REQ_CHAR, 8'h80, 8'h00, 8'h00, 8'h00);
            stop_requests();
            wait_quiet();
        end
    endtask

    task automatic test_random_traffic(input int count, input int sender_gap,
                                       input int receiver_stall);
        gap_pct   = sender_gap;
        stall_pct = receiver_stall;
        set_attributes(8'($urandom), 8'($urandom));
        for (int i = 0; i < count; i++)
            send_random_request();
        stop_requests();
        wait_quiet();
    endtask

    task automatic test_receiver_hold_off();
        gap_pct   = 0;
        stall_pct = 0;
        hold_req_cnt <= hold_req_cnt + 1;
        for (int i = 0; i < 16; i++)
            send_random_request();
        stop_requests();
        wait_quiet();
    endtask

    initial
    begin
        cursor_col_m = 8'd0;
        cursor_row_m = 8'd0;
        bg_attr_m    = BG_ATTR_RESET;
        fg_attr_m    = FG_ATTR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_values();
        test_directed_requests();
        test_attribute_settings();
        test_random_traffic(65, 20, 58);
        test_random_traffic(65, 58, 20);
        test_random_traffic(60, 0, 0);
        test_receiver_hold_off();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/txc_pkg.sv
rtl/core/txc_cfg.sv
rtl/core/txc_front.sv
rtl/core/txc_queue.sv
rtl/core/txc_back.sv
rtl/core/text_console_char_writer.sv
tb/testbench.sv
